>>> hdl/top_k_score_selector_top_macros.svh
// Assertion macros for the top-k selector RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef TOP_K_SCORE_SELECTOR_TOP_MACROS_SVH
`define TOP_K_SCORE_SELECTOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define TKS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TKS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tks_pkg.sv
// Package for the top-k score selector: field widths, constants, shared types.
// No dependencies; used by the interfaces and all modules.
package tks_pkg;

    localparam int ID_W      = 12;
    localparam int KEY_W     = 16;
    localparam int HELD_W    = 5;
    localparam int LIMIT_W   = 8;

    // limit fallback and lower bound of valid keep_limit values
    localparam int FALLBACK_LIMIT = 10;
    localparam int MIN_LIMIT      = 3;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(FALLBACK_LIMIT);

    // offered candidate
    typedef struct packed {
        logic [ID_W-1:0]  board_id;
        logic [KEY_W-1:0] score;
        logic [KEY_W-1:0] online_count;
    } t_cand;

    // controller to datapath commands
    typedef struct packed {
        logic insert;   // place the candidate into the cell row
        logic shift;    // move the row up one place (read-out)
        logic blank;    // drive zero payload (empty table result)
    } t_dp_cmd;

    // controller side of the result channel
    typedef struct packed {
        logic              valid;
        logic              valid_res;
        logic              last;
        logic [HELD_W-1:0] held_count;
    } t_out_ctl;

endpackage

>>> hdl/tks_cfg_if.sv
// Configuration write channel: keep_limit register data with valid/ready.
// Depends on tks_pkg.
interface tks_cfg_if;
    import tks_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] keep_limit;

    modport source (output valid, output keep_limit, input ready);
    modport sink   (input valid, input keep_limit, output ready);
endinterface

>>> hdl/tks_in_if.sv
// Input channel: one candidate or end-of-scan request with valid/ready.
// Depends on tks_pkg.
interface tks_in_if;
    import tks_pkg::*;

    logic             valid;
    logic             ready;
    logic             mode;
    logic             eligible;
    logic [ID_W-1:0]  board_id;
    logic [KEY_W-1:0] score;
    logic [KEY_W-1:0] online_count;

    modport source (output valid, output mode, output eligible, output board_id,
                    output score, output online_count, input ready);
    modport sink   (input valid, input mode, input eligible, input board_id,
                    input score, input online_count, output ready);
endinterface

>>> hdl/tks_out_if.sv
// Result channel: one ranked entry per transfer, with valid/ready.
// Depends on tks_pkg.
interface tks_out_if;
    import tks_pkg::*;

    logic              valid;
    logic              ready;
    logic              valid_res;
    logic [ID_W-1:0]   rank_board;
    logic [KEY_W-1:0]  rank_score;
    logic [HELD_W-1:0] held_count;
    logic              last;

    modport source (output valid, output valid_res, output rank_board, output rank_score,
                    output held_count, output last, input ready);
    modport sink   (input valid, input valid_res, input rank_board, input rank_score,
                    input held_count, input last, output ready);
endinterface

>>> hdl/tks_datapath.sv
// Datapath of the top-k selector: row of compare-and-shift cells.
// Depends on tks_pkg; driven by tks_controller commands.
module tks_datapath #(
    parameter int MAX_TOP = 16,
    parameter int CNT_W   = $clog2(MAX_TOP + 1)
) (
    input  logic                      i_clk,
    input  tks_pkg::t_dp_cmd          i_cmd,
    input  logic [CNT_W-1:0]          i_count,
    input  tks_pkg::t_cand            i_cand,
    output logic [tks_pkg::ID_W-1:0]  o_rank_board,
    output logic [tks_pkg::KEY_W-1:0] o_rank_score
);
    import tks_pkg::*;

    logic [ID_W-1:0]  r_id     [MAX_TOP];
    logic [KEY_W-1:0] r_score  [MAX_TOP];
    logic [KEY_W-1:0] r_online [MAX_TOP];

    // per cell: candidate goes at or before this place (empty cells count as beaten)
    logic [MAX_TOP-1:0] w_take;

    for (genvar k = 0; k < MAX_TOP; k++) begin : g_cell
        logic w_used;
        logic w_beats;

        assign w_used  = CNT_W'(k) < i_count;
        assign w_beats = (i_cand.score > r_score[k]) ||
                         ((i_cand.score == r_score[k]) &&
                          (i_cand.online_count > r_online[k]));
        assign w_take[k] = !w_used || w_beats;

        // insert: first taking cell loads the candidate, later ones take the upper neighbor
        // shift: move one place toward the head for read-out
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && w_take[k]) begin
                    r_id[k]     <= i_cand.board_id;
                    r_score[k]  <= i_cand.score;
                    r_online[k] <= i_cand.online_count;
                end else if (i_cmd.shift && MAX_TOP > 1) begin
                    r_id[k]     <= r_id[(MAX_TOP > 1) ? 1 : 0];
                    r_score[k]  <= r_score[(MAX_TOP > 1) ? 1 : 0];
                    r_online[k] <= r_online[(MAX_TOP > 1) ? 1 : 0];
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && w_take[k]) begin
                    if (!w_take[k-1]) begin
                        r_id[k]     <= i_cand.board_id;
                        r_score[k]  <= i_cand.score;
                        r_online[k] <= i_cand.online_count;
                    end else begin
                        r_id[k]     <= r_id[k-1];
                        r_score[k]  <= r_score[k-1];
                        r_online[k] <= r_online[k-1];
                    end
                end else if (i_cmd.shift && k < MAX_TOP - 1) begin
                    r_id[k]     <= r_id[(k < MAX_TOP - 1) ? k + 1 : k];
                    r_score[k]  <= r_score[(k < MAX_TOP - 1) ? k + 1 : k];
                    r_online[k] <= r_online[(k < MAX_TOP - 1) ? k + 1 : k];
                end
            end
        end
    end

    // head cell is the current rank during read-out
    assign o_rank_board = i_cmd.blank ? '0 : r_id[0];
    assign o_rank_score = i_cmd.blank ? '0 : r_score[0];

endmodule

>>> hdl/tks_controller.sv
// Controller of the top-k selector: handshakes, limit register, fill count, read-out.
// Depends on tks_pkg and top_k_score_selector_top_macros.svh.
`include "top_k_score_selector_top_macros.svh"

module tks_controller #(
    parameter int MAX_TOP = 16,
    parameter int CNT_W   = $clog2(MAX_TOP + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [tks_pkg::LIMIT_W-1:0] i_cfg_data,
    output logic                        o_cfg_ready,
    input  logic                        i_in_valid,
    input  logic                        i_mode,
    input  logic                        i_eligible,
    output logic                        o_in_ready,
    input  logic                        i_out_ready,
    output tks_pkg::t_out_ctl           o_out,
    output tks_pkg::t_dp_cmd            o_cmd,
    output logic [CNT_W-1:0]            o_count
);
    import tks_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int FALL_LIM = (FALLBACK_LIMIT > MAX_TOP) ? MAX_TOP : FALLBACK_LIMIT;

    logic [1:0]         r_state,  n_state;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [CNT_W-1:0]   r_remain, n_remain;
    logic [LIMIT_W-1:0] r_limit;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_offer;
    logic [CNT_W-1:0] w_lim;

    // limit register; write only while idle (the block itself does not enforce this)
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // effective limit: out-of-range values fall back
    always_comb begin
        if (int'(r_limit) >= MIN_LIMIT && int'(r_limit) <= MAX_TOP) begin
            w_lim = CNT_W'(r_limit);
        end else begin
            w_lim = CNT_W'(FALL_LIM);
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_offer    = w_in_acc && !i_mode && i_eligible;
    assign w_out_acc  = o_out.valid && i_out_ready;

    // next state
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_remain = r_remain;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_mode) begin
                    n_remain = r_count;
                    n_state  = (r_count == '0) ? ST_EMPTY : ST_READ;
                end else if (w_offer && r_count < w_lim) begin
                    n_count = r_count + 1'b1;
                end
            end
            ST_READ: begin
                if (w_out_acc) begin
                    n_remain = r_remain - 1'b1;
                    if (r_remain == CNT_W'(1)) begin
                        n_count = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (w_out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_remain <= n_remain;
        end
    end

    // datapath commands
    assign o_cmd.insert = w_offer;
    assign o_cmd.shift  = (r_state == ST_READ) && w_out_acc;
    assign o_cmd.blank  = (r_state == ST_EMPTY);
    assign o_count      = r_count;

    // result channel control fields
    assign o_out.valid      = (r_state == ST_READ) || (r_state == ST_EMPTY);
    assign o_out.valid_res  = (r_state == ST_READ);
    assign o_out.last       = (r_state == ST_EMPTY) || (r_remain == CNT_W'(1));
    assign o_out.held_count = HELD_W'(r_count);

    `TKS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_TOP), "fill count above table size")
    `TKS_ASSERT_IMP(a_remain_ok, r_state == ST_READ, r_remain != '0 && r_remain <= r_count, "read-out counter out of range")
    `TKS_ASSERT_NXT(a_drain_clears, r_state == ST_READ && w_out_acc && o_out.last, r_state == ST_IDLE && r_count == '0, "table not cleared after last result")
    `TKS_ASSERT_NXT(a_grow, w_offer && r_count < w_lim, r_count == $past(r_count) + 1'b1, "table did not grow on insert")
    `TKS_ASSERT_IMP(a_cmd_excl, 1'b1, !(o_cmd.insert && o_cmd.shift), "insert and shift together")

endmodule

>>> hdl/top_k_score_selector_top.sv
// Offer: a new candidate is accepted every cycle while scanning (cell row).
// End of scan: results start the next cycle, one per cycle while taken, n results for n held
// entries (one for an empty table); no input is accepted until the last result is taken.
// Synchronous active-low reset empties the table, returns to scanning, sets keep_limit to 10;
// the entry cells themselves are not cleared.
// Top level of the top-k score selector; depends on tks_pkg, the channel interfaces,
// tks_controller and tks_datapath.
module top_k_score_selector_top #(
    parameter int MAX_TOP = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tks_cfg_if.sink   i_cfg,
    tks_in_if.sink    i_in,
    tks_out_if.source o_out
);
    import tks_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOP + 1);

    t_dp_cmd          w_cmd;
    t_out_ctl         w_out;
    t_cand            w_cand;
    logic [CNT_W-1:0] w_count;

    assign w_cand.board_id     = i_in.board_id;
    assign w_cand.score        = i_in.score;
    assign w_cand.online_count = i_in.online_count;

    tks_controller #(
        .MAX_TOP (MAX_TOP),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.keep_limit),
        .o_cfg_ready (i_cfg.ready),
        .i_in_valid  (i_in.valid),
        .i_mode      (i_in.mode),
        .i_eligible  (i_in.eligible),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out       (w_out),
        .o_cmd       (w_cmd),
        .o_count     (w_count)
    );

    tks_datapath #(
        .MAX_TOP (MAX_TOP),
        .CNT_W   (CNT_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_count      (w_count),
        .i_cand       (w_cand),
        .o_rank_board (o_out.rank_board),
        .o_rank_score (o_out.rank_score)
    );

    assign o_out.valid      = w_out.valid;
    assign o_out.valid_res  = w_out.valid_res;
    assign o_out.held_count = w_out.held_count;
    assign o_out.last       = w_out.last;

endmodule
